// ===== hw/rtl/pid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_pkg
// Shared types and constants for the pid controller with settle tracking.
// ----------------------------------------------------------------------------
package pid_pkg;

    // milliseconds that one error sample stands for
    localparam int STEP_MS = 10;

    // time counters
    localparam int CNT_W = 17;
    typedef logic [CNT_W-1:0] t_cnt;
    localparam t_cnt CNT_MAX = {CNT_W{1'b1}};

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // register indexes
    localparam t_cfg_idx REG_PROP_GAIN   = 3'd0;
    localparam t_cfg_idx REG_INTEG_GAIN  = 3'd1;
    localparam t_cfg_idx REG_DERIV_GAIN  = 3'd2;
    localparam t_cfg_idx REG_INTEG_WIN   = 3'd3;
    localparam t_cfg_idx REG_SETTLE_BAND = 3'd4;
    localparam t_cfg_idx REG_SETTLE_TIME = 3'd5;
    localparam t_cfg_idx REG_TIMEOUT     = 3'd6;

    // data types
    typedef logic signed [15:0] t_error;
    typedef logic signed [31:0] t_drive;
    typedef logic [14:0]        t_window;

endpackage

// ===== hw/rtl/pid_controller_with_settle.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_with_settle
// Discrete PID controller on Q8.8 error samples with settle and timeout flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_ready with i_error_sample, one signed
//   Q8.8 error sample per 10 ms control step.
//   Output channel: o_out_valid / i_out_ready with o_drive (signed Q16.16,
//   saturated) and o_is_settled, exactly one result per sample, in order.
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx at the
//   clock edge; write only while no sample is in flight.
//   Pipeline: three register stages (state update, gain multiply, sum and
//   saturate), passed in that order; a result becomes valid once the sum
//   and saturate stage has registered it.
//   Throughput: one sample per cycle while o_in_ready is high; the integral,
//   last error and time counters are updated in the cycle a sample
//   transfers, so the next sample can follow at once.
//   Reset (synchronous, active low) clears gains, limits, controller state
//   and the pipeline.
//   Receiver stall: each of the three stages holds its item while the next
//   one is full; input keeps being taken until all three are full.
// ----------------------------------------------------------------------------
module pid_controller_with_settle (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_we,
    input  pid_pkg::t_cfg_idx   i_cfg_idx,
    input  pid_pkg::t_cfg_data  i_cfg_data,
    // error samples
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pid_pkg::t_error     i_error_sample,
    // results
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pid_pkg::t_drive     o_drive,
    output logic                o_is_settled
);
    import pid_pkg::*;

    // configuration registers
    logic [15:0] r_prop_gain, r_integ_gain, r_deriv_gain;
    t_window     r_integ_win, r_settle_band;
    logic [15:0] r_settle_time, r_timeout;

    // controller state
    logic signed [31:0] r_integral_sum, n_integral_sum;
    t_error             r_last_error;
    t_cnt               r_settled_ms, n_settled_ms;
    t_cnt               r_running_ms, n_running_ms;

    // pipeline control
    logic r_s1_valid, r_s2_valid, r_out_valid;
    logic s1_ready, s2_ready, s3_ready;
    logic s1_move, s2_move, in_xfer, out_xfer;

    // stage 1 payload
    t_error             r_s1_e;
    logic signed [16:0] r_s1_diff, n_s1_diff;
    logic signed [31:0] r_s1_integ;
    logic               r_s1_done, n_done;

    // stage 2 payload
    logic signed [32:0] r_p_prop, n_p_prop;
    logic signed [48:0] r_p_integ, n_p_integ;
    logic signed [33:0] r_p_deriv, n_p_deriv;
    logic               r_s2_done;

    // stage 3 payload
    t_drive             r_drive, n_drive;
    logic               r_settled;
    logic signed [49:0] n_sum;

    // state update helpers
    logic signed [16:0] e_ext;
    logic [16:0]        e_mag;
    logic signed [32:0] integ_add;
    logic               sign_flip;
    logic [17:0]        settled_inc, running_inc;

    // handshake between stages
    assign s3_ready   = !r_out_valid || i_out_ready;
    assign s2_move    = r_s2_valid && s3_ready;
    assign s2_ready   = !r_s2_valid || s3_ready;
    assign s1_move    = r_s1_valid && s2_ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign in_xfer    = i_in_valid && s1_ready;
    assign out_xfer   = r_out_valid && i_out_ready;
    assign o_in_ready = s1_ready;

    // configuration write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain   <= '0;
            r_integ_gain  <= '0;
            r_deriv_gain  <= '0;
            r_integ_win   <= '0;
            r_settle_band <= '0;
            r_settle_time <= '0;
            r_timeout     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PROP_GAIN:   r_prop_gain   <= i_cfg_data;
                REG_INTEG_GAIN:  r_integ_gain  <= i_cfg_data;
                REG_DERIV_GAIN:  r_deriv_gain  <= i_cfg_data;
                REG_INTEG_WIN:   r_integ_win   <= i_cfg_data[14:0];
                REG_SETTLE_BAND: r_settle_band <= i_cfg_data[14:0];
                REG_SETTLE_TIME: r_settle_time <= i_cfg_data;
                REG_TIMEOUT:     r_timeout     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // magnitude and sign flip of the incoming sample
    always_comb begin
        e_ext     = {i_error_sample[15], i_error_sample};
        e_mag     = i_error_sample[15] ? 17'(-e_ext) : 17'(e_ext);
        sign_flip = (!i_error_sample[15] && (i_error_sample != '0) && r_last_error[15]) ||
                    (i_error_sample[15] && !r_last_error[15] && (r_last_error != '0));
        n_s1_diff = e_ext - {r_last_error[15], r_last_error};
    end

    // saturating integral, accumulated only while the error magnitude is below the window, cleared on a sign flip
    always_comb begin
        integ_add      = {r_integral_sum[31], r_integral_sum} + 33'(e_ext);
        n_integral_sum = r_integral_sum;
        if (e_mag < {2'b00, r_integ_win}) begin
            if (integ_add[32] != integ_add[31])
                n_integral_sum = integ_add[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            else
                n_integral_sum = integ_add[31:0];
        end
        if (sign_flip)
            n_integral_sum = '0;
    end

    // settled and running time, saturating; settled time restarts from zero outside the settle band
    always_comb begin
        settled_inc  = {1'b0, r_settled_ms} + 18'(STEP_MS);
        running_inc  = {1'b0, r_running_ms} + 18'(STEP_MS);
        n_running_ms = running_inc[17] ? CNT_MAX : running_inc[CNT_W-1:0];
        if (e_mag < {2'b00, r_settle_band})
            n_settled_ms = settled_inc[17] ? CNT_MAX : settled_inc[CNT_W-1:0];
        else
            n_settled_ms = '0;
        n_done = ((r_timeout != '0) && (n_running_ms > {1'b0, r_timeout})) ||
                 (n_settled_ms > {1'b0, r_settle_time});
    end

    // state registers, updated on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral_sum <= '0;
            r_last_error   <= '0;
            r_settled_ms   <= '0;
            r_running_ms   <= '0;
        end else if (in_xfer) begin
            r_integral_sum <= n_integral_sum;
            r_last_error   <= i_error_sample;
            r_settled_ms   <= n_settled_ms;
            r_running_ms   <= n_running_ms;
        end
    end

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer)
                r_s1_valid <= 1'b1;
            else if (s1_move)
                r_s1_valid <= 1'b0;
            if (s1_move)
                r_s2_valid <= 1'b1;
            else if (s2_move)
                r_s2_valid <= 1'b0;
            if (s2_move)
                r_out_valid <= 1'b1;
            else if (out_xfer)
                r_out_valid <= 1'b0;
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_e     <= i_error_sample;
            r_s1_diff  <= n_s1_diff;
            r_s1_integ <= n_integral_sum;
            r_s1_done  <= n_done;
        end
    end

    // gain products
    always_comb begin
        n_p_prop  = $signed({1'b0, r_prop_gain}) * r_s1_e;
        n_p_integ = $signed({1'b0, r_integ_gain}) * r_s1_integ;
        n_p_deriv = $signed({1'b0, r_deriv_gain}) * r_s1_diff;
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_p_prop  <= n_p_prop;
            r_p_integ <= n_p_integ;
            r_p_deriv <= n_p_deriv;
            r_s2_done <= r_s1_done;
        end
    end

    // sum of products and output saturation
    always_comb begin
        n_sum = 50'(r_p_prop) + 50'(r_p_integ) + 50'(r_p_deriv);
        if ((n_sum[49:31] != '0) && (n_sum[49:31] != '1))
            n_drive = n_sum[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            n_drive = n_sum[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_drive   <= n_drive;
            r_settled <= r_s2_done;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_drive      = r_drive;
    assign o_is_settled = r_settled;

    // checks
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_xfer |=> $stable(r_integral_sum) && $stable(r_running_ms))
        else $error("controller state changed without an input transfer");

    a_settled_le_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_settled_ms <= r_running_ms)
        else $error("settled time exceeds running time");

    a_flip_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && sign_flip |=> r_integral_sum == '0)
        else $error("integral not cleared on error sign flip");

    a_s2_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_move |=> r_out_valid)
        else $error("result lost between product stage and output");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s2_ready |=> r_s1_valid && $stable(r_s1_integ))
        else $error("stage 1 item overwritten while stalled");

endmodule
